[rtl/lobm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// shared types and codes for the order book matcher
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int BOOK_DEPTH_DEF = 32;

   localparam logic [1:0] OP_LIMIT  = 2'd0;
   localparam logic [1:0] OP_MARKET = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] KIND_TRADE     = 3'd0;
   localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
   localparam logic [2:0] KIND_CANCELLED = 3'd2;
   localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
   localparam logic [2:0] KIND_REJECTED  = 3'd4;

   // one resting order
   typedef struct packed {
      logic [31:0] oid;
      logic [15:0] trader;
      logic [31:0] price;
      logic [31:0] qty;
      logic [47:0] ts;
   } entry_type;

   // book operation codes
   localparam logic [1:0] BK_HOLD   = 2'd0;
   localparam logic [1:0] BK_INSERT = 2'd1;
   localparam logic [1:0] BK_REMOVE = 2'd2;
   localparam logic [1:0] BK_TOPQTY = 2'd3;

   // command sent from the controller to a book
   typedef struct packed {
      logic [1:0]  op;
      logic        is_bid;
      entry_type   ent;
      logic [31:0] match_oid;
      logic [31:0] top_qty;
   } book_cmd_type;

endpackage

[rtl/limit_order_book_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// price-time priority matching engine with bounded bid and ask books
// ----------------------------------------------------------------------------
// Each book is a row of BOOK_DEPTH cells kept sorted by price then time; an
// insert or a removal shifts the row by one slot. A request is captured into
// registers; an order then trades against the top of the opposite book, each
// fill removing that top entry or reducing its quantity, until the sweep ends,
// and then gives its final result or makes the resting insert. A cancel goes
// straight to its final result; an unused opcode is dropped with no result.
// Output stalls hold the sweep. Results leave through an output register; the
// next request is taken once the final result of the current one has been
// loaded into that register.
// Both books are empty after reset.
module limit_order_book_matcher
   import lobm_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   // side[0], price_ticks[32:1], quantity[64:33], trader_id[80:65],
   // timestamp[128:81], cancel_id[160:129], zero fill to 168
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // kind[2:0]
   output logic [2:0]   rsp_tuser,
   // order_id[31:0], buyer_id[47:32], seller_id[63:48], trade_price[95:64],
   // trade_qty[127:96], aggressor_side[128], mid_valid[129],
   // mid_half_ticks[162:130], zero fill to 168
   output logic [167:0] rsp_tdata,
   output logic         rsp_tlast
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic        side_ff;
   logic [31:0] price_ff, rem_ff, cid_ff, oid_ff, next_oid_ff;
   logic [15:0] trader_ff;
   logic [47:0] ts_ff;
   logic        ovalid_ff, olast_ff;
   logic [167:0] odata_ff;
   logic [2:0]  kind_ff;

   logic [167:0] odata_in;
   logic [2:0]   kind_in;
   logic         emit_in, last_in;

   book_cmd_type bcmd, acmd;
   entry_type    btop, atop, otop;
   logic         bvalid, avalid, bfull, afull, bfound, afound, ovld, stop;
   logic         can_emit;
   logic [31:0]  fill;

   lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
      .clock(clock), .reset(reset), .cmd(bcmd), .top(btop), .top_valid(bvalid),
      .full(bfull), .found(bfound));
   lobm_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
      .clock(clock), .reset(reset), .cmd(acmd), .top(atop), .top_valid(avalid),
      .full(afull), .found(afound));

   assign can_emit   = ~ovalid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign otop = side_ff ? btop : atop;
   assign ovld = side_ff ? bvalid : avalid;
   assign fill = (rem_ff < otop.qty) ? rem_ff : otop.qty;
   // limit price stops the sweep
   assign stop = (op_ff == OP_LIMIT) &&
                 (side_ff ? (otop.price < price_ff) : (otop.price > price_ff));

   // controller
   always_comb begin
      book_cmd_type c;
      logic [167:0] d;
      logic [2:0]   k;
      logic         emit, lst;
      state_in  = state_ff;
      c.op      = BK_HOLD;
      c.is_bid  = 1'b0;
      c.ent     = '{oid: oid_ff, trader: trader_ff, price: price_ff, qty: rem_ff, ts: ts_ff};
      c.match_oid = cid_ff;
      c.top_qty = otop.qty - fill;
      bcmd = c;
      acmd = c;
      bcmd.is_bid = 1'b1;
      emit = 1'b0;
      lst  = 1'b0;
      k    = KIND_ACCEPTED;
      d    = '0;
      d[31:0] = oid_ff;
      d[128]  = side_ff;
      case (state_ff)
         ST_IDLE: ;
         ST_MATCH: begin
            if (can_emit) begin
               if (ovld && rem_ff != 32'd0 && !stop) begin
                  emit = 1'b1;
                  k          = KIND_TRADE;
                  d[47:32]   = side_ff ? otop.trader : trader_ff;
                  d[63:48]   = side_ff ? trader_ff : otop.trader;
                  d[95:64]   = otop.price;
                  d[127:96]  = fill;
                  d[129]     = bvalid & avalid;
                  d[162:130] = (bvalid & avalid) ?
                               ({1'b0, btop.price} + {1'b0, atop.price}) : 33'd0;
                  if (side_ff) bcmd.op = (fill == otop.qty) ? BK_REMOVE : BK_TOPQTY;
                  else         acmd.op = (fill == otop.qty) ? BK_REMOVE : BK_TOPQTY;
                  bcmd.match_oid = btop.oid;
                  acmd.match_oid = atop.oid;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (can_emit) begin
               emit = 1'b1;
               lst  = 1'b1;
               state_in = ST_IDLE;
               if (op_ff == OP_CANCEL) begin
                  d[128]  = 1'b0;
                  d[31:0] = cid_ff;
                  if (bfound) begin
                     k = KIND_CANCELLED;
                     bcmd.op = BK_REMOVE;
                  end else if (afound) begin
                     k = KIND_CANCELLED;
                     acmd.op = BK_REMOVE;
                  end else begin
                     k = KIND_NOTFOUND;
                  end
               end else if (op_ff == OP_LIMIT && rem_ff != 32'd0) begin
                  if (side_ff ? afull : bfull) k = KIND_REJECTED;
                  else begin
                     k = KIND_ACCEPTED;
                     if (side_ff) acmd.op = BK_INSERT;
                     else         bcmd.op = BK_INSERT;
                  end
               end else begin
                  k = KIND_ACCEPTED;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      odata_in = d;
      kind_in  = k;
      emit_in  = emit;
      last_in  = lst;
   end

   // request capture, order state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         next_oid_ff <= 32'd1;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_in) ovalid_ff <= 1'b1;
         else if (rsp_tready) ovalid_ff <= 1'b0;
         if (req_tvalid && req_tready && req_tuser != OP_UNUSED) begin
            state_ff <= (req_tuser == OP_CANCEL) ? ST_FINAL : ST_MATCH;
            if (req_tuser != OP_CANCEL) next_oid_ff <= next_oid_ff + 32'd1;
         end
      end
      if (req_tvalid && req_tready) begin
         op_ff     <= req_tuser;
         side_ff   <= req_tdata[0];
         price_ff  <= req_tdata[32:1];
         rem_ff    <= req_tdata[64:33];
         trader_ff <= req_tdata[80:65];
         ts_ff     <= req_tdata[128:81];
         cid_ff    <= req_tdata[160:129];
         oid_ff    <= next_oid_ff;
      end else if (state_ff == ST_MATCH && emit_in) begin
         rem_ff <= rem_ff - fill;
      end
      if (emit_in) begin
         odata_ff <= odata_in;
         kind_ff  <= kind_in;
         olast_ff <= last_in;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = olast_ff;

`ifndef ASSERT_OFF
   // no request taken while an order is in progress
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request accepted while busy");
   // a held result is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable({rsp_tuser, rsp_tdata, rsp_tlast}))
      else $error("result changed while stalled");
   // a trade never exceeds remaining quantity
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH && emit_in) |-> (fill <= rem_ff && fill != 32'd0))
      else $error("bad fill");
   // final result returns to idle
   a_last: assert property (@(posedge clock) disable iff (reset)
      (emit_in && last_in) |=> (state_ff == ST_IDLE))
      else $error("last without idle");
`endif

endmodule

[rtl/lobm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_cell
// one slot of a sorted book; shifts with its neighbors on insert and remove
// ----------------------------------------------------------------------------
module lobm_cell
   import lobm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  book_cmd_type cmd,
   input  logic         is_top,
   input  entry_type    prev_ent,
   input  logic         prev_valid,
   input  logic         prev_after,
   input  logic         prev_kill,
   input  entry_type    next_ent,
   input  logic         next_valid,
   output entry_type    ent,
   output logic         valid,
   output logic         after,
   output logic         kill
);

   entry_type ent_ff, ent_in;
   logic      valid_ff, valid_in;
   logic      ahead;
   logic      pa, pk;

   // new entry goes ahead of this one
   always_comb begin
      if (cmd.ent.price != ent_ff.price)
         ahead = cmd.is_bid ? (cmd.ent.price > ent_ff.price)
                            : (cmd.ent.price < ent_ff.price);
      else
         ahead = cmd.ent.ts < ent_ff.ts;
   end

   assign pa = is_top ? 1'b0 : prev_after;
   assign pk = is_top ? 1'b0 : prev_kill;
   // insert position is at or before this cell
   assign after = pa | (valid_ff & ahead) | ~valid_ff;
   // removal point is at or before this cell
   assign kill  = pk | (valid_ff & (ent_ff.oid == cmd.match_oid));

   // next slot content
   always_comb begin
      ent_in   = ent_ff;
      valid_in = valid_ff;
      case (cmd.op)
         BK_INSERT: begin
            if (pa) begin
               ent_in   = prev_ent;
               valid_in = prev_valid;
            end else if (after) begin
               ent_in   = cmd.ent;
               valid_in = 1'b1;
            end
         end
         BK_REMOVE: begin
            if (kill) begin
               ent_in   = next_ent;
               valid_in = next_valid;
            end
         end
         BK_TOPQTY: begin
            if (is_top) ent_in.qty = cmd.top_qty;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign ent   = ent_ff;
   assign valid = valid_ff;

endmodule

[rtl/lobm_book.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_book
// one side of the book as a row of sorted cells
// ----------------------------------------------------------------------------
module lobm_book
   import lobm_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  book_cmd_type cmd,
   output entry_type    top,
   output logic         top_valid,
   output logic         full,
   output logic         found
);

   entry_type ents [BOOK_DEPTH];
   logic [BOOK_DEPTH-1:0] vld, aft, kil;

   for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      lobm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .is_top     (g == 0),
         .prev_ent   (ents[(g == 0) ? 0 : g - 1]),
         .prev_valid (vld[(g == 0) ? 0 : g - 1]),
         .prev_after (aft[(g == 0) ? 0 : g - 1]),
         .prev_kill  (kil[(g == 0) ? 0 : g - 1]),
         .next_ent   (ents[(g == BOOK_DEPTH - 1) ? g : g + 1]),
         .next_valid ((g == BOOK_DEPTH - 1) ? 1'b0 : vld[(g == BOOK_DEPTH - 1) ? g : g + 1]),
         .ent        (ents[g]),
         .valid      (vld[g]),
         .after      (aft[g]),
         .kill       (kil[g])
      );
   end

   assign top       = ents[0];
   assign top_valid = vld[0];
   assign full      = vld[BOOK_DEPTH-1];
   assign found     = kil[BOOK_DEPTH-1];

endmodule
